// ===== rtl/lrb_pkg.sv =====
// Shared definitions for the Bresenham line rasterizer.
// No dependencies; used by every module under rtl.
package lrb_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

endpackage

// ===== rtl/lrb_front.sv =====
// Front end: classifies an incoming item and precomputes line setup
// (spans, step directions, active flag). Depends on lrb_pkg.
module lrb_front #(
  parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF,
  localparam int IN_BITS   = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int ENTRY_BITS = 6 * COORD_BITS + 4
) (
  input  logic [IN_BITS-1:0]    in_data,
  input  logic                  in_mode,
  output logic [ENTRY_BITS-1:0] entry
);

  localparam int C = COORD_BITS;

  logic signed [C-1:0] x0, y0, x1, y1;
  logic signed [C:0]   dx, dy, ndx, ndy;
  logic                neg_x, neg_y, act;
  logic [C-1:0]        span_x, span_y;

  always_comb begin
    x0 = in_data[C-1:0];
    y0 = in_data[2*C-1:C];
    x1 = in_data[3*C-1:2*C];
    y1 = in_data[4*C-1:3*C];
    dx = {x1[C-1], x1} - {x0[C-1], x0};
    dy = {y1[C-1], y1} - {y0[C-1], y0};
    ndx = '0 - dx;
    ndy = '0 - dy;
    neg_x = dx[C] || (dx == '0);
    neg_y = dy[C] || (dy == '0);
    span_x = neg_x ? ndx[C-1:0] : dx[C-1:0];
    span_y = neg_y ? ndy[C-1:0] : dy[C-1:0];
    act = (x0 != x1) || (y0 != y1);
    entry = {in_mode, act, neg_x, neg_y, x0, y0, x1, y1, span_x, span_y};
  end

endmodule

// ===== rtl/lrb_queue.sv =====
// Short register queue between front end and stepper.
// Depends on lrb_pkg for its depth.
module lrb_queue #(
  parameter int WIDTH = 8,
  localparam int DEPTH = lrb_pkg::QUEUE_DEPTH,
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push, do_pop;

  assign push_ready = (count != CNT_BITS'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lrb_back.sv =====
// Stepper: holds the line state, runs one Bresenham step per step item of
// an active line and registers the resulting pixel. Depends on lrb_pkg.
module lrb_back #(
  parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF,
  localparam int ENTRY_BITS = 6 * COORD_BITS + 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_ready,
  input  logic [ENTRY_BITS-1:0]   q_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   out_x,
  output logic [COORD_BITS-1:0]   out_y,
  output logic                    out_last,
  output logic                    out_fin
);

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 2;

  logic                e_mode, e_act, e_nx, e_ny;
  logic [C-1:0]        e_x0, e_y0, e_x1, e_y1, e_sx, e_sy;

  logic [C-1:0]        pos_x, pos_y, goal_x, goal_y, span_x, span_y;
  logic                step_x_neg, step_y_neg, line_active;
  logic signed [E-1:0] error_term;

  logic                take;
  logic signed [E:0]   e2, sx_e, sy_e, err_e, err_sum;
  logic                mv_x, mv_y;
  logic [C-1:0]        nxt_x, nxt_y;
  logic                at_goal;

  assign {e_mode, e_act, e_nx, e_ny, e_x0, e_y0, e_x1, e_y1, e_sx, e_sy} = q_data;

  assign take    = q_valid && (!out_valid || out_ready);
  assign q_ready = !out_valid || out_ready;

  always_comb begin
    sx_e    = {3'b000, span_x};
    sy_e    = {3'b000, span_y};
    err_e   = {error_term[E-1], error_term};
    e2      = {error_term, 1'b0};
    mv_x    = (e2 >= -sy_e);
    mv_y    = (e2 <= sx_e);
    err_sum = err_e - (mv_x ? sy_e : '0) + (mv_y ? sx_e : '0);
    nxt_x   = mv_x ? (step_x_neg ? pos_x - 1'b1 : pos_x + 1'b1) : pos_x;
    nxt_y   = mv_y ? (step_y_neg ? pos_y - 1'b1 : pos_y + 1'b1) : pos_y;
    at_goal = (nxt_x == goal_x) && (nxt_y == goal_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x       <= '0;
      pos_y       <= '0;
      goal_x      <= '0;
      goal_y      <= '0;
      span_x      <= '0;
      span_y      <= '0;
      step_x_neg  <= 1'b0;
      step_y_neg  <= 1'b0;
      error_term  <= '0;
      line_active <= 1'b0;
    end else if (take) begin
      if (e_mode == lrb_pkg::MODE_LOAD) begin
        pos_x       <= e_x0;
        pos_y       <= e_y0;
        goal_x      <= e_x1;
        goal_y      <= e_y1;
        span_x      <= e_sx;
        span_y      <= e_sy;
        step_x_neg  <= e_nx;
        step_y_neg  <= e_ny;
        error_term  <= {2'b00, e_sx} - {2'b00, e_sy};
        line_active <= e_act;
      end else if (line_active) begin
        pos_x       <= nxt_x;
        pos_y       <= nxt_y;
        error_term  <= err_sum[E-1:0];
        line_active <= !at_goal;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (e_mode == lrb_pkg::MODE_LOAD) begin
        out_x    <= e_x0;
        out_y    <= e_y0;
        out_last <= !e_act;
        out_fin  <= 1'b0;
      end else if (!line_active) begin
        out_x    <= pos_x;
        out_y    <= pos_y;
        out_last <= (pos_x == goal_x) && (pos_y == goal_y);
        out_fin  <= 1'b1;
      end else begin
        out_x    <= nxt_x;
        out_y    <= nxt_y;
        out_last <= at_goal;
        out_fin  <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/line_raster_bresenham.sv =====
// Top level of the all-octant Bresenham line rasterizer.
// Instantiates lrb_front, lrb_queue and lrb_back; depends on lrb_pkg.
//
// The block takes one item per clock while the output is not stalled and
// returns one pixel per item, so a line of N pixels comes from its load
// item and N-1 step items. A result passes through the two-entry queue
// behind the setup logic and then through the stepper's output register.
// The sustained rate of one item per cycle is set by the stepper, which
// updates error term and position together as it takes each item.
// A load item (tuser = 0) emits the start pixel; step items (tuser = 1)
// emit the following pixels, tlast marks the end pixel, and a step past
// the end repeats the end pixel with the finished flag set.
module line_raster_bresenham #(
  parameter int COORD_BITS = lrb_pkg::COORD_BITS_DEF,
  localparam int IN_BITS    = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int ENTRY_BITS = 6 * COORD_BITS + 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,   // start_x, start_y, stop_x, stop_y
  input  logic                s_tuser,   // mode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata,   // pixel_x, pixel_y
  output logic                m_tlast,   // last
  output logic                m_tuser    // finished_already
);

  logic [ENTRY_BITS-1:0] f_entry, q_entry;
  logic                  q_valid, q_ready;
  logic [COORD_BITS-1:0] px, py;

  lrb_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_data (s_tdata),
    .in_mode (s_tuser),
    .entry   (f_entry)
  );

  lrb_queue #(.WIDTH(ENTRY_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_data  (f_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_entry)
  );

  lrb_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_entry),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (px),
    .out_y     (py),
    .out_last  (m_tlast),
    .out_fin   (m_tuser)
  );

  assign m_tdata = OUT_BITS'({py, px});

endmodule
